@@ src/regret_matching_table_core_assert.svh @@
// Assertion macros for the regret-matching table core.
`ifndef REGRET_MATCHING_TABLE_CORE_ASSERT_SVH
`define REGRET_MATCHING_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define RMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/rmt_pkg.sv @@
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared constants, types and helpers of the regret-matching table core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmt_pkg;

  localparam int CARD_COUNT   = 36;
  localparam int ACTION_SLOTS = 4;
  localparam int OUT_SLOTS    = 4;
  localparam int ENTRY_W      = 31;
  localparam int PROB_W       = 17;
  localparam int SUM_W        = 33;
  localparam int NUM_W        = 48;
  localparam int QUOT_W       = 17;
  localparam int DIV_STEPS    = 17;

  localparam logic [1:0] FUNC_REGRET  = 2'd0;
  localparam logic [1:0] FUNC_STRAT   = 2'd1;
  localparam logic [1:0] FUNC_CURRENT = 2'd2;
  localparam logic [1:0] FUNC_AVERAGE = 2'd3;

  localparam logic [ENTRY_W-1:0] ENTRY_MAX     = '1;
  localparam logic [SUM_W-1:0]   AVG_THRESHOLD = SUM_W'(655);
  localparam logic [2:0]         NUM_ACT_RESET = 3'd4;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_resp_t;

  function automatic logic [PROB_W-1:0] even_share(input logic [2:0] n);
    logic [PROB_W-1:0] p;
    case (n)
      3'd1:    p = PROB_W'(65536);
      3'd2:    p = PROB_W'(32768);
      3'd3:    p = PROB_W'(21845);
      3'd4:    p = PROB_W'(16384);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ src/rmt_if.sv @@
// ----------------------------------------------------------------------------
// rmt_in_if / rmt_out_if
// Valid/ready channels carrying the item and result payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmt_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic [5:0]                        card_one;
  logic [5:0]                        card_two;
  logic [1:0]                        action_index;
  logic signed [31:0]                action_utility;
  logic signed [31:0]                infoset_utility;
  logic [rmt_pkg::PROB_W-1:0]        reach_weight;
  logic [rmt_pkg::PROB_W-1:0]        prob_in_0;
  logic [rmt_pkg::PROB_W-1:0]        prob_in_1;
  logic [rmt_pkg::PROB_W-1:0]        prob_in_2;
  logic [rmt_pkg::PROB_W-1:0]        prob_in_3;

  modport source (output valid, func, card_one, card_two, action_index, action_utility,
                  infoset_utility, reach_weight, prob_in_0, prob_in_1, prob_in_2,
                  prob_in_3, input ready);
  modport sink (input valid, func, card_one, card_two, action_index, action_utility,
                infoset_utility, reach_weight, prob_in_0, prob_in_1, prob_in_2,
                prob_in_3, output ready);
endinterface

interface rmt_out_if;
  logic                       valid;
  logic                       ready;
  logic [rmt_pkg::PROB_W-1:0] prob_out_0;
  logic [rmt_pkg::PROB_W-1:0] prob_out_1;
  logic [rmt_pkg::PROB_W-1:0] prob_out_2;
  logic [rmt_pkg::PROB_W-1:0] prob_out_3;
  logic                       saturated;

  modport source (output valid, prob_out_0, prob_out_1, prob_out_2, prob_out_3, saturated,
                  input ready);
  modport sink (input valid, prob_out_0, prob_out_1, prob_out_2, prob_out_3, saturated,
                output ready);
endinterface

`default_nettype wire

@@ src/rmt_div.sv @@
// ----------------------------------------------------------------------------
// rmt_div
// Restoring divider, one quotient bit per cycle, quotient below 2^17.
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rmt_pkg::div_req_t  req,
  output rmt_pkg::div_resp_t      resp
);

  localparam int REM_W = rmt_pkg::NUM_W + 2;
  localparam int CNT_W = $clog2(rmt_pkg::DIV_STEPS);

  logic                       busy_r;
  logic                       done_r;
  logic [REM_W-1:0]           rem_r;
  logic [REM_W-1:0]           dvs_r;
  logic [rmt_pkg::QUOT_W-1:0] quot_r;
  logic [CNT_W-1:0]           cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= {2'b00, req.num};
        dvs_r  <= {1'b0, req.den, 16'b0};
        quot_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_r >= dvs_r) begin
          rem_r  <= rem_r - dvs_r;
          quot_r <= {quot_r[rmt_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          quot_r <= {quot_r[rmt_pkg::QUOT_W-2:0], 1'b0};
        end
        dvs_r <= dvs_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(rmt_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign resp.done = done_r;
  assign resp.quot = quot_r;

endmodule

`default_nettype wire

@@ src/regret_matching_table_core.sv @@
// ----------------------------------------------------------------------------
// regret_matching_table_core
// Regret and strategy-sum tables of one decision node with CFR+ updates and
// current / average strategy queries, using one shared iterative divider.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        func, cards, action, utilities, weights
//   out_ch   out  valid/ready        prob_out_0..3, saturated
//   cfg      in   cfg_we             cfg_data = legal action count
//
// After reset a clearing pass writes CARD_COUNT*CARD_COUNT (1296) rows and
// in_ch.ready stays low. One item at a time: a regret update sets one entry,
// a strategy-sum update adds rounded weight*prob to each active entry, and a
// query sums the active entries, then shares evenly or divides each through
// the 17-step divider; a card out of range skips to the result. A stalled
// result holds in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "regret_matching_table_core_assert.svh"

module regret_matching_table_core #(
  parameter int CARD_COUNT   = rmt_pkg::CARD_COUNT,
  parameter int ACTION_SLOTS = rmt_pkg::ACTION_SLOTS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rmt_in_if.sink          in_ch,
  rmt_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_data
);

  localparam int EW       = rmt_pkg::ENTRY_W;
  localparam int PW       = rmt_pkg::PROB_W;
  localparam int ROWS     = CARD_COUNT * CARD_COUNT;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_BITS = ACTION_SLOTS * EW;
  localparam int CAP      = (ACTION_SLOTS < rmt_pkg::OUT_SLOTS) ? ACTION_SLOTS
                                                                : rmt_pkg::OUT_SLOTS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_ADD, S_SUM, S_DIV_START, S_DIV_WAIT,
    S_WRITE, S_DONE
  } state_t;

  state_t                     state_r;
  logic [2:0]                 act_count_r;
  logic [ROW_W-1:0]           clr_cnt_r;

  logic [1:0]                 func_r;
  logic [1:0]                 act_r;
  logic signed [31:0]         au_r;
  logic signed [31:0]         iu_r;
  logic [PW-1:0]              w_r;
  logic [PW-1:0]              p_r [rmt_pkg::OUT_SLOTS];
  logic [ROW_W-1:0]           row_addr_r;
  logic [2:0]                 n_r;
  logic [ROW_BITS-1:0]        row_r;
  logic [1:0]                 idx_r;
  logic [rmt_pkg::SUM_W-1:0]  sum_r;
  logic [2*PW-1:0]            prod_r;
  logic                       sat_r;
  logic [PW-1:0]              prob_r [rmt_pkg::OUT_SLOTS];

  logic                       out_valid_r;
  logic [PW-1:0]              out_prob_r [rmt_pkg::OUT_SLOTS];
  logic                       out_sat_r;

  logic [ROW_BITS-1:0]        rg_mem [ROWS];
  logic [ROW_BITS-1:0]        ss_mem [ROWS];
  logic [ROW_BITS-1:0]        rg_rd_r;
  logic [ROW_BITS-1:0]        ss_rd_r;

  rmt_pkg::div_req_t          div_req;
  rmt_pkg::div_resp_t         div_resp;

  logic                       in_xfer;
  logic                       card_ok;
  logic [ROW_W-1:0]           rd_addr;
  logic [2:0]                 n_act;
  logic [EW-1:0]              entry;
  logic signed [34:0]         rg_sum;
  logic [EW-1:0]              rg_new;
  logic                       rg_sat;
  logic [32:0]                ss_sum;
  logic [EW-1:0]              ss_new;
  logic                       norm_ok;
  logic                       last_idx;
  logic                       out_free;
  logic                       out_load;
  logic                       mem_we;
  logic [ROW_W-1:0]           mem_addr;
  logic [ROW_BITS-1:0]        mem_data;
  logic                       rg_we;
  logic                       ss_we;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign card_ok = (in_ch.card_one != 6'd0) && (32'(in_ch.card_one) <= CARD_COUNT) &&
                   (in_ch.card_two != 6'd0) && (32'(in_ch.card_two) <= CARD_COUNT);
  assign rd_addr = ROW_W'((32'(in_ch.card_one) - 32'd1) * CARD_COUNT +
                          32'(in_ch.card_two) - 32'd1);

  always_comb begin
    n_act = act_count_r;
    if (n_act == 3'd0) begin
      n_act = 3'd1;
    end
    if (32'(n_act) > CAP) begin
      n_act = 3'(CAP);
    end
  end

  assign entry    = row_r[32'(idx_r) * EW +: EW];
  assign last_idx = (3'(idx_r) + 3'd1 == n_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == S_DONE) && out_free;

  assign rg_sum = 35'(signed'({1'b0, row_r[32'(act_r) * EW +: EW]})) + 35'(au_r) - 35'(iu_r);
  always_comb begin
    rg_sat = 1'b0;
    if (rg_sum < 0) begin
      rg_new = '0;
    end else if (rg_sum > 35'(signed'({1'b0, rmt_pkg::ENTRY_MAX}))) begin
      rg_new = rmt_pkg::ENTRY_MAX;
      rg_sat = 1'b1;
    end else begin
      rg_new = rg_sum[EW-1:0];
    end
  end

  assign ss_sum = 33'(entry) + 33'((prod_r + 34'd32768) >> 16);
  assign ss_new = (ss_sum > 33'(rmt_pkg::ENTRY_MAX)) ? rmt_pkg::ENTRY_MAX : ss_sum[EW-1:0];

  assign norm_ok = (func_r == rmt_pkg::FUNC_CURRENT) ? (sum_r != '0)
                                                     : (sum_r > rmt_pkg::AVG_THRESHOLD);

  assign div_req.start = (state_r == S_DIV_START) && norm_ok;
  assign div_req.num   = rmt_pkg::NUM_W'({entry, 16'b0}) + rmt_pkg::NUM_W'(sum_r >> 1);
  assign div_req.den   = sum_r;

  rmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .resp  (div_resp)
  );

  always_comb begin
    rg_we    = 1'b0;
    ss_we    = 1'b0;
    mem_addr = row_addr_r;
    mem_data = row_r;
    if (state_r == S_CLEAR) begin
      rg_we    = 1'b1;
      ss_we    = 1'b1;
      mem_addr = clr_cnt_r;
      mem_data = '0;
    end else if (state_r == S_WRITE) begin
      rg_we = (func_r == rmt_pkg::FUNC_REGRET);
      ss_we = (func_r == rmt_pkg::FUNC_STRAT);
    end
  end
  assign mem_we = rg_we || ss_we;

  always_ff @(posedge clk) begin
    if (rg_we) begin
      rg_mem[mem_addr] <= mem_data;
    end
    if (ss_we) begin
      ss_mem[mem_addr] <= mem_data;
    end
    rg_rd_r <= rg_mem[rd_addr];
    ss_rd_r <= ss_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_count_r <= rmt_pkg::NUM_ACT_RESET;
    end else if (cfg_we) begin
      act_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            func_r     <= in_ch.func;
            act_r      <= in_ch.action_index;
            au_r       <= in_ch.action_utility;
            iu_r       <= in_ch.infoset_utility;
            w_r        <= in_ch.reach_weight;
            p_r[0]     <= in_ch.prob_in_0;
            p_r[1]     <= in_ch.prob_in_1;
            p_r[2]     <= in_ch.prob_in_2;
            p_r[3]     <= in_ch.prob_in_3;
            row_addr_r <= rd_addr;
            n_r        <= n_act;
            idx_r      <= '0;
            sum_r      <= '0;
            sat_r      <= 1'b0;
            for (int a = 0; a < rmt_pkg::OUT_SLOTS; a++) begin
              prob_r[a] <= '0;
            end
            state_r <= card_ok ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          row_r   <= func_r[0] ? ss_rd_r : rg_rd_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          case (func_r)
            rmt_pkg::FUNC_REGRET: begin
              if (32'(act_r) < ACTION_SLOTS) begin
                row_r[32'(act_r) * EW +: EW] <= rg_new;
                sat_r   <= rg_sat;
                state_r <= S_WRITE;
              end else begin
                state_r <= S_DONE;
              end
            end
            rmt_pkg::FUNC_STRAT: state_r <= S_MUL;
            default:             state_r <= S_SUM;
          endcase
        end
        S_MUL: begin
          prod_r  <= w_r * p_r[idx_r];
          state_r <= S_ADD;
        end
        S_ADD: begin
          row_r[32'(idx_r) * EW +: EW] <= ss_new;
          if (ss_sum > 33'(rmt_pkg::ENTRY_MAX)) begin
            sat_r <= 1'b1;
          end
          idx_r   <= idx_r + 1'b1;
          state_r <= last_idx ? S_WRITE : S_MUL;
        end
        S_SUM: begin
          sum_r <= sum_r + rmt_pkg::SUM_W'(entry);
          if (last_idx) begin
            idx_r   <= '0;
            state_r <= S_DIV_START;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DIV_START: begin
          if (!norm_ok) begin
            for (int a = 0; a < rmt_pkg::OUT_SLOTS; a++) begin
              prob_r[a] <= (a < int'(n_r)) ? rmt_pkg::even_share(n_r) : '0;
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_resp.done) begin
            prob_r[idx_r] <= div_resp.quot;
            idx_r         <= idx_r + 1'b1;
            state_r       <= last_idx ? S_DONE : S_DIV_START;
          end
        end
        S_WRITE: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            for (int a = 0; a < rmt_pkg::OUT_SLOTS; a++) begin
              out_prob_r[a] <= prob_r[a];
            end
            out_sat_r <= sat_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.prob_out_0 = out_prob_r[0];
  assign out_ch.prob_out_1 = out_prob_r[1];
  assign out_ch.prob_out_2 = out_prob_r[2];
  assign out_ch.prob_out_3 = out_prob_r[3];
  assign out_ch.saturated  = out_sat_r;

  `RMT_ASSERT_NOW(a_clear_writes, clk, rst_n, state_r == S_CLEAR, mem_we && !in_ch.ready)
  `RMT_ASSERT_NEXT(a_accept_next, clk, rst_n, in_xfer, state_r == S_READ || state_r == S_DONE)
  `RMT_ASSERT_NOW(a_div_done_wait, clk, rst_n, div_resp.done, state_r == S_DIV_WAIT)
  `RMT_ASSERT_NOW(a_write_update, clk, rst_n, state_r == S_WRITE,
                  func_r == rmt_pkg::FUNC_REGRET || func_r == rmt_pkg::FUNC_STRAT)

endmodule

`default_nettype wire

@@ sim/tb_regret_matching_table_core.sv @@
// ----------------------------------------------------------------------------
// tb_regret_matching_table_core
// Self-checking bench for the regret-matching table core. A directed table of
// items, then bursty random traffic over a small hand pool, is sent through
// the input channel under a stalling receiver. Every result is compared with
// a behavioral model of the regret and strategy-sum tables or a typed result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_regret_matching_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = rmt_pkg::CARD_COUNT * rmt_pkg::CARD_COUNT * rmt_pkg::ACTION_SLOTS;
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic [1:0]  func;
    logic [5:0]  c1;
    logic [5:0]  c2;
    logic [1:0]  act;
    logic [31:0] au;
    logic [31:0] iu;
    logic [16:0] w;
    logic [16:0] p[4];
  } item_t;

  typedef struct {
    logic [16:0] p[4];
    logic        sat;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_data = 3'd0;

  rmt_in_if  in_ch();
  rmt_out_if out_ch();

  regret_matching_table_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [30:0] regret_q[DEPTH];
  logic [30:0] ssum_q[DEPTH];
  logic [2:0]  num_act_q;
  res_t        expected_q[$];
  int          mismatches = 0;
  longint      cycles = 0;

  function automatic int active_count();
    int n;
    n = num_act_q;
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    return n;
  endfunction

  function automatic void normalize_row(bit avg, int base, int n, ref res_t r);
    longint unsigned s, v;
    s = 0;
    for (int a = 0; a < n; a++) s += avg ? ssum_q[base + a] : regret_q[base + a];
    for (int a = 0; a < n; a++) begin
      v = avg ? ssum_q[base + a] : regret_q[base + a];
      if (s > (avg ? 655 : 0) && s != 0) r.p[a] = 17'((v * 65536 + s / 2) / s);
      else r.p[a] = 17'((65536 + n / 2) / n);
    end
  endfunction

  function automatic res_t predict_table(item_t it);
    res_t r;
    int n, base;
    longint v;
    longint unsigned s, inc;
    n = active_count();
    r.sat = 1'b0;
    for (int a = 0; a < 4; a++) r.p[a] = '0;
    if (it.c1 >= 1 && it.c1 <= rmt_pkg::CARD_COUNT && it.c2 >= 1 &&
        it.c2 <= rmt_pkg::CARD_COUNT) begin
      base = ((it.c1 - 1) * rmt_pkg::CARD_COUNT + (it.c2 - 1)) * rmt_pkg::ACTION_SLOTS;
      case (it.func)
        rmt_pkg::FUNC_REGRET: begin
          v = longint'(regret_q[base + it.act]) + longint'($signed(it.au))
              - longint'($signed(it.iu));
          if (v < 0) v = 0;
          if (v > 64'h7FFFFFFF) begin
            v = 64'h7FFFFFFF;
            r.sat = 1'b1;
          end
          regret_q[base + it.act] = 31'(v);
        end
        rmt_pkg::FUNC_STRAT: begin
          for (int a = 0; a < n; a++) begin
            inc = (longint'(it.w) * it.p[a] + 32768) >> 16;
            s = ssum_q[base + a] + inc;
            if (s > 64'h7FFFFFFF) begin
              s = 64'h7FFFFFFF;
              r.sat = 1'b1;
            end
            ssum_q[base + a] = 31'(s);
          end
        end
        rmt_pkg::FUNC_CURRENT: normalize_row(1'b0, base, n, r);
        default: normalize_row(1'b1, base, n, r);
      endcase
    end
    return r;
  endfunction

  // directed rows; dir_chk marks rows whose result is typed in
  item_t dir_q[$];
  res_t  dir_res[$];
  bit    dir_chk[$];

  task automatic add_row(logic [1:0] f, int c1, int c2, int act, logic [31:0] au,
                         logic [31:0] iu, int w, int p0, int p1, int p2, int p3,
                         bit chk, int r0, int r1, int r2, int r3, bit sat);
    item_t it;
    res_t r;
    it.func = f; it.c1 = 6'(c1); it.c2 = 6'(c2); it.act = 2'(act);
    it.au = au; it.iu = iu; it.w = 17'(w);
    it.p[0] = 17'(p0); it.p[1] = 17'(p1); it.p[2] = 17'(p2); it.p[3] = 17'(p3);
    r.p[0] = 17'(r0); r.p[1] = 17'(r1); r.p[2] = 17'(r2); r.p[3] = 17'(r3);
    r.sat = sat;
    dir_q.push_back(it);
    dir_res.push_back(r);
    dir_chk.push_back(chk);
  endtask

  task automatic send_item(item_t it);
    res_t r;
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.card_one <= it.c1;
    in_ch.card_two <= it.c2;
    in_ch.action_index <= it.act;
    in_ch.action_utility <= it.au;
    in_ch.infoset_utility <= it.iu;
    in_ch.reach_weight <= it.w;
    in_ch.prob_in_0 <= it.p[0];
    in_ch.prob_in_1 <= it.p[1];
    in_ch.prob_in_2 <= it.p[2];
    in_ch.prob_in_3 <= it.p[3];
    do @(posedge clk); while (!in_ch.ready);
    r = predict_table(it);
    expected_q.push_back(r);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_and_set(logic [2:0] n);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    num_act_q = n;
  endtask

  function automatic item_t rand_item();
    item_t it;
    int k;
    k = $urandom_range(0, 99);
    it.func = 2'($urandom_range(0, 3));
    it.c1 = 6'($urandom_range(1, 3));
    it.c2 = 6'($urandom_range(1, 3));
    if (k < 4) it.c1 = 6'($urandom_range(0, 63));
    if (k >= 4 && k < 8) it.c2 = 6'($urandom_range(0, 63));
    it.act = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) begin
      it.au = $urandom();
      it.iu = $urandom();
    end else begin
      it.au = 32'($signed($urandom_range(0, 400000)) - 200000);
      it.iu = 32'($signed($urandom_range(0, 400000)) - 200000);
    end
    it.w = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 131071))
                                       : 17'($urandom_range(0, 65536));
    for (int a = 0; a < 4; a++)
      it.p[a] = ($urandom_range(0, 5) == 0) ? 17'($urandom_range(0, 131071))
                                            : 17'($urandom_range(0, 65536));
    return it;
  endfunction

  // receiver: stall pattern with quiet stretches
  always @(posedge clk) begin
    int ph;
    cycles <= cycles + 1;
    ph = int'(cycles % 400);
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (ph < 100) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    res_t e;
    bit bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer at cycle %0d", cycles);
      end else begin
        e = expected_q.pop_front();
        bad = (out_ch.prob_out_0 !== e.p[0]) || (out_ch.prob_out_1 !== e.p[1]) ||
              (out_ch.prob_out_2 !== e.p[2]) || (out_ch.prob_out_3 !== e.p[3]) ||
              (out_ch.saturated !== e.sat);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %0d sat %0b, got %0d %0d %0d %0d sat %0b",
                     e.p[0], e.p[1], e.p[2], e.p[3], e.sat, out_ch.prob_out_0,
                     out_ch.prob_out_1, out_ch.prob_out_2, out_ch.prob_out_3,
                     out_ch.saturated);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    item_t it;
    res_t  r;
    int    burst;
    logic [2:0] settings[5] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7};
    in_ch.valid = 1'b0;
    in_ch.func = rmt_pkg::FUNC_REGRET;
    in_ch.card_one = '0;
    in_ch.card_two = '0;
    in_ch.action_index = '0;
    in_ch.action_utility = '0;
    in_ch.infoset_utility = '0;
    in_ch.reach_weight = '0;
    in_ch.prob_in_0 = '0;
    in_ch.prob_in_1 = '0;
    in_ch.prob_in_2 = '0;
    in_ch.prob_in_3 = '0;
    for (int i = 0; i < DEPTH; i++) begin
      regret_q[i] = '0;
      ssum_q[i] = '0;
    end
    num_act_q = rmt_pkg::NUM_ACT_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_row(rmt_pkg::FUNC_CURRENT, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0,
            1, 16384, 16384, 16384, 16384, 0);
    add_row(rmt_pkg::FUNC_AVERAGE, 36, 36, 0, 0, 0, 0, 0, 0, 0, 0,
            1, 16384, 16384, 16384, 16384, 0);
    add_row(rmt_pkg::FUNC_REGRET, 0, 5, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0,
            1, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_CURRENT, 37, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_AVERAGE, 1, 63, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_REGRET, 2, 2, 1, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0,
            1, 0, 0, 0, 0, 1);
    add_row(rmt_pkg::FUNC_REGRET, 2, 2, 3, 32'h00010000, 0, 0, 0, 0, 0, 0,
            1, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_CURRENT, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_REGRET, 2, 2, 1, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 0,
            1, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_CURRENT, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 65536, 0);
    add_row(rmt_pkg::FUNC_STRAT, 3, 4, 0, 0, 0, 65536, 65536, 131071, 0, 1,
            1, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_AVERAGE, 3, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_STRAT, 5, 5, 0, 0, 0, 131071, 131071, 131071, 131071, 131071,
            0, 0, 0, 0, 0, 0);
    for (int k = 0; k < 8; k++)
      add_row(rmt_pkg::FUNC_STRAT, 5, 5, 0, 0, 0, 131071, 131071, 131071, 131071, 131071,
              0, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_AVERAGE, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0,
            1, 16384, 16384, 16384, 16384, 0);
    add_row(rmt_pkg::FUNC_STRAT, 6, 6, 0, 0, 0, 1, 655, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(rmt_pkg::FUNC_AVERAGE, 6, 6, 0, 0, 0, 0, 0, 0, 0, 0,
            1, 16384, 16384, 16384, 16384, 0);

    for (int i = 0; i < dir_q.size(); i++) begin
      it = dir_q[i];
      send_item(it);
      if (dir_chk[i]) begin
        r = expected_q[expected_q.size() - 1];
        if (r.p != dir_res[i].p || r.sat != dir_res[i].sat)
          $display("directed row %0d: table disagrees with model", i);
        expected_q[expected_q.size() - 1] = dir_res[i];
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_and_set(ph == 5 ? 3'd4 : settings[ph]);
      for (int i = 0; i < 150; i++) begin
        burst = $urandom_range(0, 1);
        if (burst == 0) idle_gap();
        send_item(rand_item());
      end
    end
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire
